// ===== hw/rtl/ebcc_pkg.sv =====
package ebcc_pkg;

	typedef enum logic [3:0] {
		ST_VEC_LO      = 4'd0,
		ST_VEC_HI      = 4'd1,
		ST_OPCODE      = 4'd2,
		ST_OPER1       = 4'd3,
		ST_ABS_LO      = 4'd4,
		ST_ABS_HI      = 4'd5,
		ST_LOAD_A      = 4'd6,
		ST_WDONE       = 4'd7,
		ST_PULL        = 4'd8,
		ST_RTS_LO      = 4'd9,
		ST_RTS_HI      = 4'd10,
		ST_IND_LO      = 4'd11,
		ST_IND_HI      = 4'd12,
		ST_JSR_PUSH_LO = 4'd13,
		ST_JSR_JUMP    = 4'd14
	} step_t;

	localparam logic [15:0] STACK_BASE   = 16'h0100;
	localparam logic [15:0] RESET_VECTOR = 16'hFFFC;
	localparam logic [7:0]  SP_RESET     = 8'hFD;

	localparam logic [7:0] OP_TAX = 8'hAA, OP_TXA = 8'h8A, OP_DEX = 8'hCA, OP_INX = 8'hE8;
	localparam logic [7:0] OP_TAY = 8'hA8, OP_TYA = 8'h98, OP_DEY = 8'h88, OP_INY = 8'hC8;
	localparam logic [7:0] OP_TSX = 8'hBA, OP_TXS = 8'h9A, OP_PHA = 8'h48, OP_PHP = 8'h08;
	localparam logic [7:0] OP_PLA = 8'h68, OP_PLP = 8'h28, OP_RTS = 8'h60;
	localparam logic [7:0] OP_LDA_IMM = 8'hA9, OP_LDA_ZP = 8'hA5, OP_LDA_ZPX = 8'hB5;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2, OP_STA_ABS = 8'h8D, OP_JMP_ABS = 8'h4C;
	localparam logic [7:0] OP_JMP_IND = 8'h6C, OP_JSR = 8'h20;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [7:0]  p;
		logic [15:0] pc;
		logic [7:0]  op;
		logic [7:0]  lo;
		logic [7:0]  hi;
		step_t       step;
	} cpu_state_t;

	typedef struct packed {
		logic [15:0] addr;
		logic        we;
		logic [7:0]  wd;
		logic        of;
		logic        unk;
	} bus_req_t;

	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		set_nz = {v[7], p[6:2], (v == 8'h00), p[0]};
	endfunction

endpackage

// ===== hw/rtl/ebcc_next.sv =====
module ebcc_next (
	input  logic                  rst_req,
	input  logic [7:0]            d,
	input  ebcc_pkg::cpu_state_t  cur,
	output ebcc_pkg::cpu_state_t  nxt,
	output ebcc_pkg::bus_req_t    req
);

	logic [15:0] pc1;
	logic [15:0] opw;
	logic [15:0] ret;
	logic [7:0]  sp_dec;
	logic [7:0]  sp_inc;

	always_comb begin
		pc1    = cur.pc + 16'd1;
		opw    = {cur.hi, cur.lo};
		sp_dec = cur.sp - 8'd1;
		sp_inc = cur.sp + 8'd1;
		ret    = cur.pc;
		nxt = cur;
		req = '0;
		if (!rst_req) begin
			nxt.a = '0; nxt.x = '0; nxt.y = '0; nxt.p = '0;
			nxt.sp = ebcc_pkg::SP_RESET;
			nxt.pc = '0; nxt.op = '0; nxt.lo = '0; nxt.hi = '0;
			nxt.step = ebcc_pkg::ST_VEC_LO;
			req.addr = ebcc_pkg::RESET_VECTOR;
		end else begin
			// default is an opcode fetch at the updated pc
			nxt.step = ebcc_pkg::ST_OPCODE;
			req.of = 1'b1;
			unique case (cur.step)
				ebcc_pkg::ST_VEC_LO: begin
					nxt.lo = d;
					req.of = 1'b0;
					req.addr = ebcc_pkg::RESET_VECTOR + 16'd1;
					nxt.step = ebcc_pkg::ST_VEC_HI;
				end
				ebcc_pkg::ST_VEC_HI: begin
					nxt.hi = d;
					nxt.pc = {d, cur.lo};
					req.addr = {d, cur.lo};
				end
				ebcc_pkg::ST_OPCODE: begin
					nxt.op = d;
					nxt.pc = pc1;
					unique case (d)
						ebcc_pkg::OP_TAX: begin
							nxt.x = cur.a; nxt.p = ebcc_pkg::set_nz(cur.p, cur.a);
						end
						ebcc_pkg::OP_TXA: begin
							nxt.a = cur.x; nxt.p = ebcc_pkg::set_nz(cur.p, cur.x);
						end
						ebcc_pkg::OP_DEX: begin
							nxt.x = cur.x - 8'd1;
							nxt.p = ebcc_pkg::set_nz(cur.p, cur.x - 8'd1);
						end
						ebcc_pkg::OP_INX: begin
							nxt.x = cur.x + 8'd1;
							nxt.p = ebcc_pkg::set_nz(cur.p, cur.x + 8'd1);
						end
						ebcc_pkg::OP_TAY: begin
							nxt.y = cur.a; nxt.p = ebcc_pkg::set_nz(cur.p, cur.a);
						end
						ebcc_pkg::OP_TYA: begin
							nxt.a = cur.y; nxt.p = ebcc_pkg::set_nz(cur.p, cur.y);
						end
						ebcc_pkg::OP_DEY: begin
							nxt.y = cur.y - 8'd1;
							nxt.p = ebcc_pkg::set_nz(cur.p, cur.y - 8'd1);
						end
						ebcc_pkg::OP_INY: begin
							nxt.y = cur.y + 8'd1;
							nxt.p = ebcc_pkg::set_nz(cur.p, cur.y + 8'd1);
						end
						ebcc_pkg::OP_TSX: begin
							nxt.x = cur.sp; nxt.p = ebcc_pkg::set_nz(cur.p, cur.sp);
						end
						ebcc_pkg::OP_TXS: nxt.sp = cur.x;
						ebcc_pkg::OP_PHA, ebcc_pkg::OP_PHP: begin
							req.of = 1'b0; req.we = 1'b1;
							req.addr = ebcc_pkg::STACK_BASE | {8'h00, cur.sp};
							req.wd = (d == ebcc_pkg::OP_PHA) ? cur.a : cur.p;
							nxt.sp = sp_dec;
							nxt.step = ebcc_pkg::ST_WDONE;
						end
						ebcc_pkg::OP_PLA, ebcc_pkg::OP_PLP, ebcc_pkg::OP_RTS: begin
							req.of = 1'b0;
							nxt.sp = sp_inc;
							req.addr = ebcc_pkg::STACK_BASE | {8'h00, sp_inc};
							nxt.step = (d == ebcc_pkg::OP_RTS) ? ebcc_pkg::ST_RTS_LO
								: ebcc_pkg::ST_PULL;
						end
						ebcc_pkg::OP_LDA_IMM, ebcc_pkg::OP_LDA_ZP, ebcc_pkg::OP_LDA_ZPX,
						ebcc_pkg::OP_LDX_IMM: begin
							req.of = 1'b0; req.addr = pc1;
							nxt.step = ebcc_pkg::ST_OPER1;
						end
						ebcc_pkg::OP_STA_ABS, ebcc_pkg::OP_JMP_ABS, ebcc_pkg::OP_JMP_IND,
						ebcc_pkg::OP_JSR: begin
							req.of = 1'b0; req.addr = pc1;
							nxt.step = ebcc_pkg::ST_ABS_LO;
						end
						default: begin
							req.unk = 1'b1;
							req.addr = pc1;
						end
					endcase
					if (req.of) req.addr = pc1;
				end
				ebcc_pkg::ST_OPER1: begin
					nxt.lo = d;
					nxt.pc = pc1;
					req.addr = pc1;
					priority case (cur.op)
						ebcc_pkg::OP_LDA_IMM: begin
							nxt.a = d; nxt.p = ebcc_pkg::set_nz(cur.p, d);
						end
						ebcc_pkg::OP_LDX_IMM: begin
							nxt.x = d; nxt.p = ebcc_pkg::set_nz(cur.p, d);
						end
						ebcc_pkg::OP_LDA_ZP: begin
							req.of = 1'b0; req.addr = {8'h00, d};
							nxt.step = ebcc_pkg::ST_LOAD_A;
						end
						default: begin
							req.of = 1'b0; req.addr = {8'h00, d + cur.x};
							nxt.step = ebcc_pkg::ST_LOAD_A;
						end
					endcase
				end
				ebcc_pkg::ST_ABS_LO: begin
					nxt.lo = d;
					nxt.pc = pc1;
					req.of = 1'b0; req.addr = pc1;
					nxt.step = ebcc_pkg::ST_ABS_HI;
				end
				ebcc_pkg::ST_ABS_HI: begin
					nxt.hi = d;
					nxt.pc = pc1;
					ret = cur.pc;
					priority case (cur.op)
						ebcc_pkg::OP_STA_ABS: begin
							req.of = 1'b0; req.we = 1'b1;
							req.addr = {d, cur.lo}; req.wd = cur.a;
							nxt.step = ebcc_pkg::ST_WDONE;
						end
						ebcc_pkg::OP_JMP_ABS: begin
							nxt.pc = {d, cur.lo}; req.addr = {d, cur.lo};
						end
						ebcc_pkg::OP_JMP_IND: begin
							req.of = 1'b0; req.addr = {d, cur.lo};
							nxt.step = ebcc_pkg::ST_IND_LO;
						end
						default: begin
							// return address is the last operand byte
							req.of = 1'b0; req.we = 1'b1;
							req.addr = ebcc_pkg::STACK_BASE | {8'h00, cur.sp};
							req.wd = ret[15:8];
							nxt.sp = sp_dec;
							nxt.step = ebcc_pkg::ST_JSR_PUSH_LO;
						end
					endcase
				end
				ebcc_pkg::ST_LOAD_A: begin
					nxt.a = d; nxt.p = ebcc_pkg::set_nz(cur.p, d);
					req.addr = cur.pc;
				end
				ebcc_pkg::ST_PULL: begin
					if (cur.op == ebcc_pkg::OP_PLA) begin
						nxt.a = d; nxt.p = ebcc_pkg::set_nz(cur.p, d);
					end else begin
						nxt.p = d;
					end
					req.addr = cur.pc;
				end
				ebcc_pkg::ST_RTS_LO: begin
					nxt.lo = d;
					nxt.sp = sp_inc;
					req.of = 1'b0;
					req.addr = ebcc_pkg::STACK_BASE | {8'h00, sp_inc};
					nxt.step = ebcc_pkg::ST_RTS_HI;
				end
				ebcc_pkg::ST_RTS_HI: begin
					nxt.hi = d;
					nxt.pc = {d, cur.lo} + 16'd1;
					req.addr = {d, cur.lo} + 16'd1;
				end
				ebcc_pkg::ST_IND_LO: begin
					nxt.lo = d;
					req.of = 1'b0; req.addr = opw + 16'd1;
					nxt.step = ebcc_pkg::ST_IND_HI;
				end
				ebcc_pkg::ST_IND_HI: begin
					nxt.hi = d;
					nxt.pc = {d, cur.lo};
					req.addr = {d, cur.lo};
				end
				ebcc_pkg::ST_JSR_PUSH_LO: begin
					ret = cur.pc - 16'd1;
					req.of = 1'b0; req.we = 1'b1;
					req.addr = ebcc_pkg::STACK_BASE | {8'h00, cur.sp};
					req.wd = ret[7:0];
					nxt.sp = sp_dec;
					nxt.step = ebcc_pkg::ST_JSR_JUMP;
				end
				ebcc_pkg::ST_JSR_JUMP: begin
					nxt.pc = opw;
					req.addr = opw;
				end
				default: req.addr = cur.pc;
			endcase
			if (cur.step == ebcc_pkg::ST_ABS_HI && cur.op != ebcc_pkg::OP_JMP_ABS
				&& cur.op != ebcc_pkg::OP_STA_ABS && cur.op != ebcc_pkg::OP_JMP_IND) begin
				req.wd = cur.pc[15:8];
			end
		end
	end

endmodule

// ===== hw/rtl/eight_bit_cpu_core_subset_unit.sv =====
// 8-bit accumulator cpu core, one bus access per request.
// input channel (valid/stall): mode (0 = reset request, 1 = bus cycle done)
// and read_data, the byte returned for the previous read access.
// output channel (valid/stall): the next access (bus_address, write_enable,
// write_data, opcode_fetch), unknown_opcode and the register file.
// every input request yields exactly one result.
// the whole instruction step is one pass of decode logic between the
// architectural registers and the result register, so out_valid rises
// in the cycle after accept.
// throughput: one request per cycle; the result register is refilled in the
// same cycle it is drained, so stall only propagates when the result is
// held and not taken.
// reset (arst_n low): output empty, registers cleared, sp = 0xfd, and the
// read of the reset vector low byte counts as already requested.
// when the receiver stalls, the result holds and in_stall rises until the
// result is taken.
module eight_bit_cpu_core_subset_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] bus_address,
	output logic        write_enable,
	output logic [7:0]  write_data,
	output logic        opcode_fetch,
	output logic        unknown_opcode,
	output logic [7:0]  accumulator_out,
	output logic [7:0]  x_out,
	output logic [7:0]  y_out,
	output logic [7:0]  stack_pointer_out,
	output logic [7:0]  status_out,
	output logic [15:0] program_counter_out
);

	ebcc_pkg::cpu_state_t state_q;
	ebcc_pkg::cpu_state_t state_nxt;
	ebcc_pkg::bus_req_t   req;
	ebcc_pkg::bus_req_t   req_q;
	logic                 accept;

	assign in_stall = out_valid & out_stall;
	assign accept   = in_valid & ~in_stall;

	ebcc_next u_next (
		.rst_req(mode),
		.d      (read_data),
		.cur    (state_q),
		.nxt    (state_nxt),
		.req    (req)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: ebcc_pkg::SP_RESET,
				p: 8'h00, pc: 16'h0000, op: 8'h00, lo: 8'h00, hi: 8'h00,
				step: ebcc_pkg::ST_VEC_LO};
			out_valid <= 1'b0;
		end else begin
			if (accept) state_q <= state_nxt;
			if (accept) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
	end

	assign bus_address         = req_q.addr;
	assign write_enable        = req_q.we;
	assign write_data          = req_q.wd;
	assign opcode_fetch        = req_q.of;
	assign unknown_opcode      = req_q.unk;
	assign accumulator_out     = state_q.a;
	assign x_out               = state_q.x;
	assign y_out               = state_q.y;
	assign stack_pointer_out   = state_q.sp;
	assign status_out          = state_q.p;
	assign program_counter_out = state_q.pc;

endmodule
